// ----- rtl/sha1sh_pkg.sv -----
// Shared types, constants and commands for the SHA-1 stream hasher.
package sha1sh_pkg;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K_CH  = 32'h5A827999;
    localparam logic [31:0] K_PA1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
    localparam logic [31:0] K_PA2 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [6:0] ROUND_LAST = 7'd79;
    localparam logic [5:0] POS_LAST   = 6'd63;
    localparam logic [5:0] POS_LEN    = 6'd56;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PAD80,
        S_PADZ,
        S_LEN,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } state_t;

    typedef enum logic [1:0] {
        SH_DATA,
        SH_PAD,
        SH_ZERO,
        SH_LEN
    } shift_sel_t;

    typedef struct packed {
        logic       shift_en;
        shift_sel_t shift_sel;
        logic       count_byte;
        logic       len_load;
        logic       work_load;
        logic       round_en;
        logic       chain_add;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic pos_last;
        logic pos_len;
        logic round_last;
    } status_t;

endpackage

// ----- rtl/sha1sh_ctrl.sv -----
// Sequencer for byte intake, padding, compression rounds and digest hand-off.
module sha1sh_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                data_valid,
    input  logic                byte_present,
    input  logic                end_of_message,
    output logic                data_stall,
    output logic                digest_valid,
    input  logic                digest_stall,
    input  sha1sh_pkg::status_t status,
    output sha1sh_pkg::cmd_t    cmd
);

    sha1sh_pkg::state_t state_reg;
    sha1sh_pkg::state_t state_next;
    sha1sh_pkg::state_t ret_reg;
    sha1sh_pkg::state_t ret_next;
    logic               out_valid_reg;
    logic               out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha1sh_pkg::S_IDLE;
            ret_reg       <= sha1sh_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd        = '0;

        case (state_reg)
            sha1sh_pkg::S_IDLE:
            begin
                if (data_valid)
                begin
                    if (byte_present)
                    begin
                        cmd.shift_en   = 1'b1;
                        cmd.shift_sel  = sha1sh_pkg::SH_DATA;
                        cmd.count_byte = 1'b1;
                    end
                    if (byte_present && status.pos_last)
                    begin
                        state_next = sha1sh_pkg::S_LOAD;
                        ret_next   = end_of_message ? sha1sh_pkg::S_PAD80 : sha1sh_pkg::S_IDLE;
                    end
                    else if (end_of_message)
                    begin
                        state_next = sha1sh_pkg::S_PAD80;
                    end
                end
            end
            sha1sh_pkg::S_PAD80:
            begin
                cmd.shift_en  = 1'b1;
                cmd.shift_sel = sha1sh_pkg::SH_PAD;
                cmd.len_load  = 1'b1;
                if (status.pos_last)
                begin
                    state_next = sha1sh_pkg::S_LOAD;
                    ret_next   = sha1sh_pkg::S_PADZ;
                end
                else
                begin
                    state_next = sha1sh_pkg::S_PADZ;
                end
            end
            sha1sh_pkg::S_PADZ:
            begin
                if (status.pos_len)
                begin
                    state_next = sha1sh_pkg::S_LEN;
                end
                else
                begin
                    cmd.shift_en  = 1'b1;
                    cmd.shift_sel = sha1sh_pkg::SH_ZERO;
                    if (status.pos_last)
                    begin
                        state_next = sha1sh_pkg::S_LOAD;
                        ret_next   = sha1sh_pkg::S_PADZ;
                    end
                end
            end
            sha1sh_pkg::S_LEN:
            begin
                cmd.shift_en  = 1'b1;
                cmd.shift_sel = sha1sh_pkg::SH_LEN;
                if (status.pos_last)
                begin
                    state_next = sha1sh_pkg::S_LOAD;
                    ret_next   = sha1sh_pkg::S_OUT;
                end
            end
            sha1sh_pkg::S_LOAD:
            begin
                cmd.work_load = 1'b1;
                state_next    = sha1sh_pkg::S_ROUND;
            end
            sha1sh_pkg::S_ROUND:
            begin
                cmd.round_en = 1'b1;
                if (status.round_last)
                begin
                    state_next = sha1sh_pkg::S_ADD;
                end
            end
            sha1sh_pkg::S_ADD:
            begin
                cmd.chain_add = 1'b1;
                state_next    = ret_reg;
            end
            sha1sh_pkg::S_OUT:
            begin
                if (!out_valid_reg || !digest_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = sha1sh_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sha1sh_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!digest_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign data_stall   = (state_reg != sha1sh_pkg::S_IDLE);
    assign digest_valid = out_valid_reg;

endmodule

// ----- rtl/sha1sh_datapath.sv -----
// Block buffer, message schedule, round logic, chaining values and digest register.
module sha1sh_datapath
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          data_byte,
    input  sha1sh_pkg::cmd_t    cmd,
    output sha1sh_pkg::status_t status,
    output logic [31:0]         digest_a,
    output logic [31:0]         digest_b,
    output logic [31:0]         digest_c,
    output logic [31:0]         digest_d,
    output logic [31:0]         digest_e
);

    // word 0 sits in the top 32 bits; bytes enter at the bottom
    logic [511:0]      blk_reg;
    logic [511:0]      blk_next;
    logic [63:0]       len_reg;
    logic [63:0]       len_next;
    logic [63:0]       total_reg;
    logic [63:0]       total_next;
    logic [5:0]        pos_reg;
    logic [5:0]        pos_next;
    logic [6:0]        round_reg;
    logic [6:0]        round_next;
    logic [31:0]       chain_reg [5];
    logic [31:0]       chain_next [5];
    logic [31:0]       work_reg [5];
    logic [31:0]       work_next [5];
    logic [31:0]       dig_reg [5];
    logic [31:0]       dig_next [5];

    logic [7:0]        shift_byte;
    logic [31:0]       sched_x;
    logic [31:0]       wt;
    logic [31:0]       f_val;
    logic [31:0]       k_val;
    logic [31:0]       t_val;
    logic [31:0]       init_val [5];

    assign init_val[0] = sha1sh_pkg::H0_INIT;
    assign init_val[1] = sha1sh_pkg::H1_INIT;
    assign init_val[2] = sha1sh_pkg::H2_INIT;
    assign init_val[3] = sha1sh_pkg::H3_INIT;
    assign init_val[4] = sha1sh_pkg::H4_INIT;

    always_comb
    begin
        case (cmd.shift_sel)
            sha1sh_pkg::SH_DATA: shift_byte = data_byte;
            sha1sh_pkg::SH_PAD:  shift_byte = sha1sh_pkg::PAD_BYTE;
            sha1sh_pkg::SH_LEN:  shift_byte = len_reg[63:56];
            default:             shift_byte = 8'h00;
        endcase
    end

    assign sched_x = blk_reg[95:64] ^ blk_reg[255:224] ^ blk_reg[447:416] ^ blk_reg[511:480];
    assign wt      = (round_reg < 7'd16) ? blk_reg[511:480] : {sched_x[30:0], sched_x[31]};

    always_comb
    begin
        case (round_reg) inside
            [7'd0:7'd19]:
            begin
                f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
                k_val = sha1sh_pkg::K_CH;
            end
            [7'd20:7'd39]:
            begin
                f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
                k_val = sha1sh_pkg::K_PA1;
            end
            [7'd40:7'd59]:
            begin
                f_val = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3])
                      | (work_reg[2] & work_reg[3]);
                k_val = sha1sh_pkg::K_MAJ;
            end
            default:
            begin
                f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
                k_val = sha1sh_pkg::K_PA2;
            end
        endcase
    end

    assign t_val = {work_reg[0][26:0], work_reg[0][31:27]} + f_val + work_reg[4] + k_val + wt;

    always_comb
    begin
        blk_next   = blk_reg;
        len_next   = len_reg;
        total_next = total_reg;
        pos_next   = pos_reg;
        round_next = round_reg;
        work_next  = work_reg;
        chain_next = chain_reg;
        dig_next   = dig_reg;

        if (cmd.shift_en)
        begin
            blk_next = {blk_reg[503:0], shift_byte};
            pos_next = pos_reg + 6'd1;
            if (cmd.shift_sel == sha1sh_pkg::SH_LEN)
            begin
                len_next = {len_reg[55:0], 8'h00};
            end
        end
        if (cmd.count_byte)
        begin
            total_next = total_reg + 64'd1;
        end
        if (cmd.len_load)
        begin
            len_next = {total_reg[60:0], 3'b000};
        end
        if (cmd.work_load)
        begin
            work_next  = chain_reg;
            round_next = '0;
        end
        if (cmd.round_en)
        begin
            blk_next     = {blk_reg[479:0], wt};
            round_next   = round_reg + 7'd1;
            work_next[0] = t_val;
            work_next[1] = work_reg[0];
            work_next[2] = {work_reg[1][1:0], work_reg[1][31:2]};
            work_next[3] = work_reg[2];
            work_next[4] = work_reg[3];
        end
        if (cmd.chain_add)
        begin
            for (int i = 0; i < 5; i++)
            begin
                chain_next[i] = chain_reg[i] + work_reg[i];
            end
        end
        if (cmd.out_load)
        begin
            dig_next   = chain_reg;
            chain_next = init_val;
            total_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            pos_reg   <= '0;
            round_reg <= '0;
            chain_reg <= init_val;
        end
        else
        begin
            total_reg <= total_next;
            pos_reg   <= pos_next;
            round_reg <= round_next;
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg  <= blk_next;
        len_reg  <= len_next;
        work_reg <= work_next;
        dig_reg  <= dig_next;
    end

    assign status.pos_last   = (pos_reg == sha1sh_pkg::POS_LAST);
    assign status.pos_len    = (pos_reg == sha1sh_pkg::POS_LEN);
    assign status.round_last = (round_reg == sha1sh_pkg::ROUND_LAST);

    assign digest_a = dig_reg[0];
    assign digest_b = dig_reg[1];
    assign digest_c = dig_reg[2];
    assign digest_d = dig_reg[3];
    assign digest_e = dig_reg[4];

endmodule

// ----- rtl/sha1_stream_hasher_top.sv -----
// SHA-1 stream hasher top level: byte items in, 160-bit digest items out.
//
// Takes one message byte per item (or none, with byte_present low) and, on an
// item with end_of_message high, returns one item with the five digest words.
// A byte is taken while data_stall is low; every 64th byte starts a compression
// (load, 80 rounds at one round per cycle, chaining add), during which
// data_stall is high. Closing a message writes the pad byte and the zero fill
// one per cycle, pauses without a write, then writes the eight length bytes one per
// cycle up to the block end; it runs one or two compressions on the way and
// then moves the digest into the output register once that register is free.
// The digest is held in its own register, so the next message may start while
// a digest waits; a second digest waits only if the first has not been taken.
module sha1_stream_hasher_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        digest_valid,
    input  logic        digest_stall,
    output logic [31:0] digest_a,
    output logic [31:0] digest_b,
    output logic [31:0] digest_c,
    output logic [31:0] digest_d,
    output logic [31:0] digest_e
);

    sha1sh_pkg::cmd_t    cmd;
    sha1sh_pkg::status_t status;

    sha1sh_ctrl u_ctrl
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_valid     (data_valid),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .data_stall     (data_stall),
        .digest_valid   (digest_valid),
        .digest_stall   (digest_stall),
        .status         (status),
        .cmd            (cmd)
    );

    sha1sh_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (data_byte),
        .cmd       (cmd),
        .status    (status),
        .digest_a  (digest_a),
        .digest_b  (digest_b),
        .digest_c  (digest_c),
        .digest_d  (digest_d),
        .digest_e  (digest_e)
    );

endmodule

// ----- bench/tb.sv -----
// Self-checking testbench for sha1_stream_hasher_top: byte items in, SHA-1 digest items out.
`timescale 1ns / 100ps

module tb;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        logic [31:0] e;
    } digest_t;

    typedef struct packed {
        logic [7:0] data;
        logic       present;
        logic       last;
        logic       fixed;
        digest_t    want;
    } stim_row_t;

    localparam digest_t EMPTY_DIGEST = 160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
    localparam digest_t ABC_DIGEST   = 160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;
    localparam digest_t NO_DIGEST    = '0;
    localparam int      N_DIRECTED   = 14;
    localparam int      N_ITEMS      = 1750;

    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_DIGEST},
        '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},
        '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
        '{8'hFF, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
        '{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
        '{8'hFF, 1'b1, 1'b1, 1'b0, NO_DIGEST},
        '{8'h80, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h7F, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_DIGEST},
        '{8'hA5, 1'b1, 1'b0, 1'b0, NO_DIGEST},
        '{8'h5A, 1'b1, 1'b1, 1'b0, NO_DIGEST}
    };

    logic        clk;
    logic        rst_n          = 1'b0;
    logic        data_valid     = 1'b0;
    logic [7:0]  data_byte      = 8'h00;
    logic        byte_present   = 1'b0;
    logic        end_of_message = 1'b0;
    logic        digest_stall   = 1'b0;
    logic        data_stall;
    logic        digest_valid;
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
    logic [31:0] digest_e;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int error_count    = 0;

    digest_t pending_digests [$];

    logic [31:0] blk_words [16];
    logic [31:0] hash_chain [5];
    logic [63:0] msg_bytes;

    sha1_stream_hasher_top DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_valid     (data_valid),
        .data_stall     (data_stall),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .digest_valid   (digest_valid),
        .digest_stall   (digest_stall),
        .digest_a       (digest_a),
        .digest_b       (digest_b),
        .digest_c       (digest_c),
        .digest_d       (digest_d),
        .digest_e       (digest_e)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(20_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void load_initial_chain();
        hash_chain[0] = sha1sh_pkg::H0_INIT;
        hash_chain[1] = sha1sh_pkg::H1_INIT;
        hash_chain[2] = sha1sh_pkg::H2_INIT;
        hash_chain[3] = sha1sh_pkg::H3_INIT;
        hash_chain[4] = sha1sh_pkg::H4_INIT;
    endfunction

    function automatic void put_msg_byte(input int pos, input logic [7:0] v);
        blk_words[pos / 4][(3 - pos % 4) * 8 +: 8] = v;
    endfunction

    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, t;
        int r;
        for (r = 0; r < 16; r++)
            w[r] = blk_words[r];
        a = hash_chain[0];
        b = hash_chain[1];
        c = hash_chain[2];
        d = hash_chain[3];
        e = hash_chain[4];
        for (r = 0; r < 80; r++)
        begin
            if (r >= 16)
            begin
                t = w[(r + 13) % 16] ^ w[(r + 8) % 16] ^ w[(r + 2) % 16] ^ w[r % 16];
                w[r % 16] = {t[30:0], t[31]};
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = sha1sh_pkg::K_CH;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = sha1sh_pkg::K_PA1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = sha1sh_pkg::K_MAJ;
            end
            else
            begin
                f = b ^ c ^ d;
                k = sha1sh_pkg::K_PA2;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[r % 16];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        hash_chain[0] += a;
        hash_chain[1] += b;
        hash_chain[2] += c;
        hash_chain[3] += d;
        hash_chain[4] += e;
    endfunction

    // Returns 1 when the item closes a message; dgst then holds its digest.
    function automatic bit hash_step(input logic [7:0] data, input logic present,
                                     input logic last, output digest_t dgst);
        int pos;
        int i;
        logic [63:0] bit_len;
        dgst = '0;
        if (present)
        begin
            pos = int'(msg_bytes[5:0]);
            put_msg_byte(pos, data);
            msg_bytes++;
            if (pos == int'(sha1sh_pkg::POS_LAST))
                compress_block();
        end
        if (!last)
            return 1'b0;
        pos = int'(msg_bytes[5:0]);
        put_msg_byte(pos, sha1sh_pkg::PAD_BYTE);
        for (i = pos + 1; i < 64; i++)
            put_msg_byte(i, 8'h00);
        if (pos >= int'(sha1sh_pkg::POS_LEN))
        begin
            compress_block();
            for (i = 0; i < 16; i++)
                blk_words[i] = '0;
        end
        bit_len = msg_bytes << 3;
        blk_words[14] = bit_len[63:32];
        blk_words[15] = bit_len[31:0];
        compress_block();
        dgst = {hash_chain[0], hash_chain[1], hash_chain[2], hash_chain[3], hash_chain[4]};
        load_initial_chain();
        msg_bytes = '0;
        return 1'b1;
    endfunction

    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic [7:0] data, input logic present, input logic last,
                             input logic fixed, input digest_t want);
        digest_t dgst;
        while ($urandom_range(99) < send_idle_pct)
        begin
            data_valid <= 1'b0;
            @(negedge clk);
        end
        data_valid     <= 1'b1;
        data_byte      <= data;
        byte_present   <= present;
        end_of_message <= last;
        @(posedge clk);
        while (data_stall)
            @(posedge clk);
        if (hash_step(data, present, last, dgst))
            pending_digests.push_back(fixed ? want : dgst);
        if (present || last)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic send_message(input int len);
        bit tail_byte;
        int i;
        tail_byte = 1'($urandom_range(1));
        for (i = 0; i < len; i++)
        begin
            if ($urandom_range(19) == 0)
                send_item(8'($urandom_range(255)), 1'b0, 1'b0, 1'b0, NO_DIGEST);
            send_item(8'($urandom_range(255)), 1'b1, tail_byte && (i == len - 1), 1'b0,
                      NO_DIGEST);
        end
        if (!tail_byte || len == 0)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1, 1'b0, NO_DIGEST);
    endtask

    initial
    begin
        forever
        begin
            @(negedge clk);
            digest_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        digest_t got;
        digest_t want;
        if (rst_n && digest_valid && !digest_stall)
        begin
            got = {digest_a, digest_b, digest_c, digest_d, digest_e};
            if (pending_digests.size() == 0)
                log_error($sformatf("unexpected digest %h", got));
            else
            begin
                want = pending_digests.pop_front();
                if (got.a !== want.a || got.b !== want.b || got.c !== want.c ||
                    got.d !== want.d || got.e !== want.e)
                    log_error($sformatf("digest mismatch: expected %h actual %h", want, got));
            end
        end
    end

    initial
    begin
        int idx;
        int sel;
        int len;
        int phase;
        int boundary_lens [10];
        boundary_lens = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
        for (idx = 0; idx < 16; idx++)
            blk_words[idx] = '0;
        load_initial_chain();
        msg_bytes = '0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_idle_pct  = 30;
        recv_stall_pct = 68;
        for (idx = 0; idx < N_DIRECTED; idx++)
            send_item(DIRECTED[idx].data, DIRECTED[idx].present, DIRECTED[idx].last,
                      DIRECTED[idx].fixed, DIRECTED[idx].want);

        items_sent = 0;
        while (items_sent < N_ITEMS)
        begin
            phase = items_sent * 3 / N_ITEMS;
            if (phase == 0)
            begin
                send_idle_pct  = 30;
                recv_stall_pct = 68;
            end
            else if (phase == 1)
            begin
                send_idle_pct  = 68;
                recv_stall_pct = 30;
            end
            else
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            sel = int'($urandom_range(99));
            if (sel < 50)
                len = int'($urandom_range(20));
            else if (sel < 80)
                len = boundary_lens[$urandom_range(9)];
            else
                len = int'($urandom_range(200));
            send_message(len);
        end
        data_valid <= 1'b0;

        while (pending_digests.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sha1sh_pkg.sv
rtl/sha1sh_ctrl.sv
rtl/sha1sh_datapath.sv
rtl/sha1_stream_hasher_top.sv
bench/tb.sv
